FILE: src/button_edge_autorepeat_top_defines.svh
// Assertion macros shared by the button edge and auto-repeat block.
`ifndef BUTTON_EDGE_AUTOREPEAT_TOP_DEFINES_SVH
`define BUTTON_EDGE_AUTOREPEAT_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define BEA_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define BEA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

FILE: src/bea_pkg.sv
// Types, constants and helpers for the button edge and auto-repeat block.
package bea_pkg;

   localparam int CFG_WIDTH = 24;
   localparam int BTN_WIDTH = 10;
   localparam int TIME_IN_WIDTH = 48;
   localparam int ACTION_WIDTH = 3;

   // Raw button word bit positions.
   localparam int BTN_DOWN = 2;
   localparam int BTN_UP = 3;
   localparam int BTN_SELECT = 4;
   localparam int BTN_BACK = 5;

   // Positions in the packed four-bit button word.
   localparam int PK_DOWN = 0;
   localparam int PK_UP = 1;
   localparam int PK_SELECT = 2;
   localparam int PK_BACK = 3;

   localparam logic [CFG_WIDTH-1:0] REPEAT_DELAY_RESET = 24'd400000;
   localparam logic [CFG_WIDTH-1:0] REPEAT_PERIOD_RESET = 24'd120000;

   typedef enum logic [0:0] {
      CSR_REPEAT_DELAY = 1'b0,
      CSR_REPEAT_PERIOD = 1'b1
   } csr_index_type;

   typedef enum logic [ACTION_WIDTH-1:0] {
      CMD_NONE = 3'd0,
      CMD_UP = 3'd1,
      CMD_DOWN = 3'd2,
      CMD_CONFIRM = 3'd3,
      CMD_CANCEL = 3'd4
   } action_type;

   // Control for one poll as it leaves the input register.
   typedef struct packed {
      logic fire;
      logic capture;
   } step_type;

   function automatic logic [3:0] pack_buttons(input logic [BTN_WIDTH-1:0] b);
      logic [3:0] p;
      p[PK_DOWN] = b[BTN_DOWN];
      p[PK_UP] = b[BTN_UP];
      p[PK_SELECT] = b[BTN_SELECT];
      p[PK_BACK] = b[BTN_BACK];
      return p;
   endfunction

endpackage

FILE: src/bea_press_detect.sv
// New-press detection with priority encoding and capture-poll handling.
module bea_press_detect (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  logic                  rearm,
   input  logic [3:0]            buttons,
   output logic                  capture,
   output bea_pkg::action_type   press_action
);

   logic [3:0] prev_ff;
   logic [3:0] prev_in;
   logic       primed_ff;
   logic       primed_in;
   logic [3:0] fresh;

   assign capture = rearm || !primed_ff;
   assign fresh = buttons & ~prev_ff;

   always_comb begin
      if (fresh[bea_pkg::PK_UP]) begin
         press_action = bea_pkg::CMD_UP;
      end else if (fresh[bea_pkg::PK_DOWN]) begin
         press_action = bea_pkg::CMD_DOWN;
      end else if (fresh[bea_pkg::PK_SELECT]) begin
         press_action = bea_pkg::CMD_CONFIRM;
      end else if (fresh[bea_pkg::PK_BACK]) begin
         press_action = bea_pkg::CMD_CANCEL;
      end else begin
         press_action = bea_pkg::CMD_NONE;
      end
   end

   always_comb begin
      prev_in = prev_ff;
      primed_in = primed_ff;
      if (fire) begin
         prev_in = buttons;
         primed_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
         primed_ff <= 1'b0;
      end else begin
         prev_ff <= prev_in;
         primed_ff <= primed_in;
      end
   end

endmodule

FILE: src/bea_dir_timer.sv
// Hold and repeat timing for one direction button.
module bea_dir_timer #(
   parameter int TIME_BITS = 48
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bea_pkg::step_type             step,
   input  logic                          pressed,
   input  logic [TIME_BITS-1:0]          now_time,
   input  logic [bea_pkg::CFG_WIDTH-1:0] delay_us,
   input  logic [bea_pkg::CFG_WIDTH-1:0] period_us,
   output logic                          repeat_hit
);

   logic                 held_ff;
   logic                 held_in;
   logic [TIME_BITS-1:0] held_since_ff;
   logic [TIME_BITS-1:0] held_since_in;
   logic [TIME_BITS-1:0] last_repeat_ff;
   logic [TIME_BITS-1:0] last_repeat_in;
   logic [TIME_BITS-1:0] since_press;
   logic [TIME_BITS-1:0] since_repeat;
   logic                 due;

   // Differences wrap modulo the time width, so a backward step looks long.
   assign since_press = now_time - held_since_ff;
   assign since_repeat = now_time - last_repeat_ff;
   assign due = (since_press >= TIME_BITS'(delay_us)) &&
                (since_repeat >= TIME_BITS'(period_us));
   assign repeat_hit = pressed && held_ff && due;

   always_comb begin
      held_in = held_ff;
      held_since_in = held_since_ff;
      last_repeat_in = last_repeat_ff;
      if (step.fire && !step.capture) begin
         if (pressed) begin
            if (!held_ff) begin
               held_in = 1'b1;
               held_since_in = now_time;
               last_repeat_in = now_time;
            end else if (due) begin
               // The repeat time moves on even when a new press wins the poll.
               last_repeat_in = now_time;
            end
         end else begin
            held_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 1'b0;
      end else begin
         held_ff <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      held_since_ff <= held_since_in;
      last_repeat_ff <= last_repeat_in;
   end

endmodule

FILE: src/button_edge_autorepeat_top.sv
// Gamepad poll decoder: press edges plus up/down auto-repeat.
//
// Usage: each req_ transaction is one poll of the pad (button word, time in
// microseconds, rearm flag). Each poll yields exactly one rsp_ transaction
// carrying an action code: none, up, down, confirm or cancel.
// The first poll after reset, or any poll with rearm set, only captures
// the buttons and answers none.
// The csr_ port writes the repeat delay (index 0) or the repeat period
// (index 1), one register per write; write them only while no poll is in flight.
// A poll waits in the input register and then moves to the result register,
// which drives rsp_valid. Throughput: one poll per cycle while rsp_ready
// is high; each poll is decoded combinationally between the two registers,
// a step that also updates the per-direction hold timers the next poll reads.
// Reset clears the pipeline, the captured buttons, the hold flags, and
// loads the delay with 400000 and the period with 120000.
// When the receiver holds rsp_ready low, the result register keeps its
// transaction and the input register still takes one more poll, after
// which req_ready drops until the result is taken.
`include "button_edge_autorepeat_top_defines.svh"

module button_edge_autorepeat_top #(
   parameter int TIME_BITS = 48
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [bea_pkg::BTN_WIDTH-1:0]     req_buttons,
   input  logic [bea_pkg::TIME_IN_WIDTH-1:0] req_time_us,
   input  logic                              req_rearm,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [bea_pkg::ACTION_WIDTH-1:0]  rsp_action,
   input  logic                              csr_write_en,
   input  logic [0:0]                        csr_index,
   input  logic [bea_pkg::CFG_WIDTH-1:0]     csr_wdata
);

   logic                          in_valid_ff;
   logic                          in_valid_in;
   logic [3:0]                    in_buttons_ff;
   logic [TIME_BITS-1:0]          in_time_ff;
   logic                          in_rearm_ff;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   bea_pkg::action_type           rsp_action_ff;
   bea_pkg::action_type           rsp_action_in;
   logic [bea_pkg::CFG_WIDTH-1:0] delay_ff;
   logic [bea_pkg::CFG_WIDTH-1:0] delay_in;
   logic [bea_pkg::CFG_WIDTH-1:0] period_ff;
   logic [bea_pkg::CFG_WIDTH-1:0] period_in;
   logic                          advance;
   logic                          req_take;
   logic                          capture;
   bea_pkg::action_type           press_action;
   bea_pkg::step_type             step;
   logic                          up_hit;
   logic                          down_hit;

   assign advance = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_action = rsp_action_ff;

   // Configuration registers.
   always_comb begin
      delay_in = delay_ff;
      period_in = period_ff;
      if (csr_write_en) begin
         case (bea_pkg::csr_index_type'(csr_index))
            bea_pkg::CSR_REPEAT_DELAY: delay_in = csr_wdata;
            bea_pkg::CSR_REPEAT_PERIOD: period_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= bea_pkg::REPEAT_DELAY_RESET;
         period_ff <= bea_pkg::REPEAT_PERIOD_RESET;
      end else begin
         delay_ff <= delay_in;
         period_ff <= period_in;
      end
   end

   // Input register.
   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_buttons_ff <= bea_pkg::pack_buttons(req_buttons);
         in_time_ff <= TIME_BITS'(req_time_us);
         in_rearm_ff <= req_rearm;
      end
   end

   bea_press_detect u_press (
      .clock        (clock),
      .reset        (reset),
      .fire         (advance),
      .rearm        (in_rearm_ff),
      .buttons      (in_buttons_ff),
      .capture      (capture),
      .press_action (press_action)
   );

   assign step.fire = advance;
   assign step.capture = capture;

   bea_dir_timer #(.TIME_BITS(TIME_BITS)) u_up_timer (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .pressed    (in_buttons_ff[bea_pkg::PK_UP]),
      .now_time   (in_time_ff),
      .delay_us   (delay_ff),
      .period_us  (period_ff),
      .repeat_hit (up_hit)
   );

   bea_dir_timer #(.TIME_BITS(TIME_BITS)) u_down_timer (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .pressed    (in_buttons_ff[bea_pkg::PK_DOWN]),
      .now_time   (in_time_ff),
      .delay_us   (delay_ff),
      .period_us  (period_ff),
      .repeat_hit (down_hit)
   );

   // A capture poll answers none; else a new press outranks any repeat; up repeats before down.
   always_comb begin
      if (capture) begin
         rsp_action_in = bea_pkg::CMD_NONE;
      end else if (press_action != bea_pkg::CMD_NONE) begin
         rsp_action_in = press_action;
      end else if (up_hit) begin
         rsp_action_in = bea_pkg::CMD_UP;
      end else if (down_hit) begin
         rsp_action_in = bea_pkg::CMD_DOWN;
      end else begin
         rsp_action_in = bea_pkg::CMD_NONE;
      end
   end

   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_action_ff <= rsp_action_in;
      end
   end

   `BEA_ASSERT_NEXT(a_capture_is_none, clock, reset, advance && capture,
      rsp_action_ff == bea_pkg::CMD_NONE)
   `BEA_ASSERT_NEXT(a_advance_fills_rsp, clock, reset, advance, rsp_valid_ff)
   `BEA_ASSERT_NEXT(a_stalled_input_held, clock, reset, in_valid_ff && !advance,
      in_valid_ff && $stable(in_buttons_ff) && $stable(in_rearm_ff))
   `BEA_ASSERT_IMPLY(a_repeat_needs_held, clock, reset, up_hit || down_hit,
      in_buttons_ff[bea_pkg::PK_UP] || in_buttons_ff[bea_pkg::PK_DOWN])

endmodule

FILE: bench/tb_top.sv
// Testbench for the gamepad poll decoder: directed table, then checked random polls.
`timescale 1ns / 100ps

module tb_top;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 4;
   localparam int PHASE_POLLS = 230;
   localparam int SCRIPT_ROWS = 27;

   localparam logic [bea_pkg::BTN_WIDTH-1:0] B_NONE = '0;
   localparam logic [bea_pkg::BTN_WIDTH-1:0] B_UP = 10'(1 << bea_pkg::BTN_UP);
   localparam logic [bea_pkg::BTN_WIDTH-1:0] B_DN = 10'(1 << bea_pkg::BTN_DOWN);
   localparam logic [bea_pkg::BTN_WIDTH-1:0] B_SEL = 10'(1 << bea_pkg::BTN_SELECT);
   localparam logic [bea_pkg::BTN_WIDTH-1:0] B_BACK = 10'(1 << bea_pkg::BTN_BACK);

   // One directed poll; set_cfg reprograms both timing registers before it.
   typedef struct packed {
      logic                              set_cfg;
      logic [bea_pkg::CFG_WIDTH-1:0]     dly;
      logic [bea_pkg::CFG_WIDTH-1:0]     per;
      logic [bea_pkg::BTN_WIDTH-1:0]     buttons;
      logic [bea_pkg::TIME_IN_WIDTH-1:0] stamp;
      logic                              rearm;
      logic                              typed;
      bea_pkg::action_type               act;
   } poll_row_type;

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_ready;
   logic [bea_pkg::BTN_WIDTH-1:0]     req_buttons;
   logic [bea_pkg::TIME_IN_WIDTH-1:0] req_time_us;
   logic                              req_rearm;
   logic                              rsp_valid;
   logic                              rsp_ready;
   logic [bea_pkg::ACTION_WIDTH-1:0]  rsp_action;
   logic                              csr_write_en;
   logic [0:0]                        csr_index;
   logic [bea_pkg::CFG_WIDTH-1:0]     csr_wdata;

   // Predictor state: timing registers and per-direction hold timers.
   logic [bea_pkg::CFG_WIDTH-1:0]     delay_cfg;
   logic [bea_pkg::CFG_WIDTH-1:0]     period_cfg;
   logic [3:0]                        last_pad;
   logic                              pad_primed;
   logic                              dir_held [2];
   logic [bea_pkg::TIME_IN_WIDTH-1:0] press_time [2];
   logic [bea_pkg::TIME_IN_WIDTH-1:0] repeat_time [2];

   bea_pkg::action_type expected_actions [$];
   poll_row_type        script [SCRIPT_ROWS];
   int                  errors = 0;
   int                  cycles = 0;
   int                  stall_left = 0;
   bit                  tx_quiet = 0;
   bit                  rx_quiet = 0;

   button_edge_autorepeat_top DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_buttons(req_buttons),
      .req_time_us(req_time_us),
      .req_rearm(req_rearm),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_action(rsp_action),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int idle_span();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Works out the action for one poll and advances the predicted state.
   function automatic bea_pkg::action_type decode_poll(
         logic [bea_pkg::BTN_WIDTH-1:0] b, logic [bea_pkg::TIME_IN_WIDTH-1:0] t,
         logic rearm);
      logic [3:0] now_pad;
      logic [3:0] fresh;
      logic [bea_pkg::TIME_IN_WIDTH-1:0] since_press;
      logic [bea_pkg::TIME_IN_WIDTH-1:0] since_rep;
      logic pressed;
      bea_pkg::action_type act;
      now_pad[bea_pkg::PK_DOWN] = b[bea_pkg::BTN_DOWN];
      now_pad[bea_pkg::PK_UP] = b[bea_pkg::BTN_UP];
      now_pad[bea_pkg::PK_SELECT] = b[bea_pkg::BTN_SELECT];
      now_pad[bea_pkg::PK_BACK] = b[bea_pkg::BTN_BACK];
      if (rearm || !pad_primed) begin
         last_pad = now_pad;
         pad_primed = 1'b1;
         return bea_pkg::CMD_NONE;
      end
      fresh = now_pad & ~last_pad;
      act = bea_pkg::CMD_NONE;
      if (fresh[bea_pkg::PK_UP]) act = bea_pkg::CMD_UP;
      else if (fresh[bea_pkg::PK_DOWN]) act = bea_pkg::CMD_DOWN;
      else if (fresh[bea_pkg::PK_SELECT]) act = bea_pkg::CMD_CONFIRM;
      else if (fresh[bea_pkg::PK_BACK]) act = bea_pkg::CMD_CANCEL;
      // Slot 0 times the up direction, slot 1 the down direction.
      for (int i = 0; i < 2; i++) begin
         pressed = (i == 0) ? now_pad[bea_pkg::PK_UP] : now_pad[bea_pkg::PK_DOWN];
         if (pressed) begin
            if (!dir_held[i]) begin
               dir_held[i] = 1'b1;
               press_time[i] = t;
               repeat_time[i] = t;
            end else begin
               since_press = t - press_time[i];
               since_rep = t - repeat_time[i];
               if (since_press >= {24'd0, delay_cfg} &&
                   since_rep >= {24'd0, period_cfg}) begin
                  if (act == bea_pkg::CMD_NONE) begin
                     act = (i == 0) ? bea_pkg::CMD_UP : bea_pkg::CMD_DOWN;
                  end
                  repeat_time[i] = t;
               end
            end
         end else begin
            dir_held[i] = 1'b0;
            press_time[i] = '0;
            repeat_time[i] = '0;
         end
      end
      last_pad = now_pad;
      return act;
   endfunction

   // Offers one poll; returns at the edge where the transaction is accepted.
   task automatic send_poll(logic [bea_pkg::BTN_WIDTH-1:0] b,
                            logic [bea_pkg::TIME_IN_WIDTH-1:0] t, logic rearm,
                            logic typed, bea_pkg::action_type typed_act);
      int gap;
      bea_pkg::action_type predicted;
      if ($urandom_range(0, 59) == 0) tx_quiet = !tx_quiet;
      gap = tx_quiet ? 0 : idle_span();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_buttons <= b;
      req_time_us <= t;
      req_rearm <= rearm;
      do @(posedge clock); while (!req_ready);
      predicted = decode_poll(b, t, rearm);
      expected_actions.push_back(typed ? typed_act : predicted);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_actions.size() != 0) @(posedge clock);
   endtask

   task automatic program_timing(logic [bea_pkg::CFG_WIDTH-1:0] dly,
                                 logic [bea_pkg::CFG_WIDTH-1:0] per);
      csr_write_en <= 1'b1;
      csr_index <= bea_pkg::CSR_REPEAT_DELAY;
      csr_wdata <= dly;
      @(posedge clock);
      csr_index <= bea_pkg::CSR_REPEAT_PERIOD;
      csr_wdata <= per;
      @(posedge clock);
      csr_write_en <= 1'b0;
      delay_cfg = dly;
      period_cfg = per;
   endtask

   // Result side: check accepted transactions and stall at random.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_actions.size() == 0) begin
            $display("%0t: action with no poll pending, expected none, got %0d",
                     $time, rsp_action);
            errors++;
         end else begin
            if (rsp_action !== expected_actions[0]) begin
               $display("%0t: action mismatch, expected %0d, got %0d",
                        $time, expected_actions[0], rsp_action);
               errors++;
            end
            void'(expected_actions.pop_front());
         end
      end
      if ($urandom_range(0, 299) == 0) rx_quiet = !rx_quiet;
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!rx_quiet && $urandom_range(0, 2) == 0) begin
         stall_left = idle_span();
         rsp_ready <= (stall_left == 0);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   initial begin
      logic [bea_pkg::CFG_WIDTH-1:0] phase_dly [6];
      logic [bea_pkg::CFG_WIDTH-1:0] phase_per [6];
      logic [bea_pkg::BTN_WIDTH-1:0] btn;
      logic [bea_pkg::TIME_IN_WIDTH-1:0] tcur;
      logic rearm;
      int scale;
      int r;

      reset <= 1'b1;
      req_valid <= 1'b0;
      req_buttons <= '0;
      req_time_us <= '0;
      req_rearm <= 1'b0;
      rsp_ready <= 1'b0;
      csr_write_en <= 1'b0;
      csr_index <= bea_pkg::CSR_REPEAT_DELAY;
      csr_wdata <= '0;

      delay_cfg = bea_pkg::REPEAT_DELAY_RESET;
      period_cfg = bea_pkg::REPEAT_PERIOD_RESET;
      last_pad = '0;
      pad_primed = 1'b0;
      for (int i = 0; i < 2; i++) begin
         dir_held[i] = 1'b0;
         press_time[i] = '0;
         repeat_time[i] = '0;
      end

      script = '{
         '{0, 0, 0, B_NONE, 48'd0, 0, 1, bea_pkg::CMD_NONE},
         '{0, 0, 0, B_UP, 48'd0, 0, 1, bea_pkg::CMD_UP},
         '{0, 0, 0, B_UP, 48'd100, 0, 0, bea_pkg::CMD_NONE},
         '{0, 0, 0, B_UP, 48'd400000, 0, 0, bea_pkg::CMD_NONE},
         '{0, 0, 0, B_UP, 48'd450000, 0, 0, bea_pkg::CMD_NONE},
         '{0, 0, 0, B_UP | B_DN, 48'd520000, 0, 0, bea_pkg::CMD_NONE},
         '{0, 0, 0, B_NONE, 48'd520001, 0, 0, bea_pkg::CMD_NONE},
         '{0, 0, 0, B_SEL, 48'd520002, 0, 1, bea_pkg::CMD_CONFIRM},
         '{0, 0, 0, B_BACK, 48'd520003, 0, 1, bea_pkg::CMD_CANCEL},
         '{0, 0, 0, 10'h3FF, 48'd520004, 0, 1, bea_pkg::CMD_UP},
         '{0, 0, 0, B_NONE, 48'd520005, 1, 1, bea_pkg::CMD_NONE},
         '{0, 0, 0, 10'h3C3, 48'd520006, 0, 1, bea_pkg::CMD_NONE},
         '{0, 0, 0, B_DN, 48'hFFFF_FFFF_FFF0, 0, 1, bea_pkg::CMD_DOWN},
         '{0, 0, 0, B_DN, 48'd10, 0, 0, bea_pkg::CMD_NONE},
         '{0, 0, 0, B_DN, 48'd5, 0, 0, bea_pkg::CMD_NONE},
         '{0, 0, 0, B_DN, 48'd6, 1, 1, bea_pkg::CMD_NONE},
         '{0, 0, 0, B_DN, 48'd7, 0, 0, bea_pkg::CMD_NONE},
         '{0, 0, 0, B_NONE, 48'hFFFF_FFFF_FFFF, 0, 0, bea_pkg::CMD_NONE},
         '{1, 24'd0, 24'd0, B_UP, 48'd50, 0, 1, bea_pkg::CMD_UP},
         '{0, 0, 0, B_UP, 48'd50, 0, 0, bea_pkg::CMD_NONE},
         '{0, 0, 0, B_UP | B_DN, 48'd51, 0, 0, bea_pkg::CMD_NONE},
         '{0, 0, 0, B_UP | B_DN, 48'd52, 0, 0, bea_pkg::CMD_NONE},
         '{1, 24'hFFFFFF, 24'hFFFFFF, B_NONE, 48'd0, 0, 1, bea_pkg::CMD_NONE},
         '{0, 0, 0, B_UP, 48'd0, 0, 1, bea_pkg::CMD_UP},
         '{0, 0, 0, B_UP, 48'hFF_FFFE, 0, 0, bea_pkg::CMD_NONE},
         '{0, 0, 0, B_UP, 48'hFF_FFFF, 0, 0, bea_pkg::CMD_NONE},
         '{0, 0, 0, B_UP | B_DN | B_SEL, 48'h100_0000, 0, 0, bea_pkg::CMD_NONE}
      };

      phase_dly[0] = bea_pkg::REPEAT_DELAY_RESET;
      phase_per[0] = bea_pkg::REPEAT_PERIOD_RESET;
      phase_dly[1] = 24'd0;               phase_per[1] = 24'd0;
      phase_dly[2] = 24'hFFFFFF;          phase_per[2] = 24'hFFFFFF;
      phase_dly[3] = 24'd0;               phase_per[3] = 24'hFFFFFF;
      phase_dly[4] = 24'hFFFFFF;          phase_per[4] = 24'd0;
      phase_dly[5] = 24'($urandom_range(0, 600000));
      phase_per[5] = 24'($urandom_range(0, 200000));

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int n = 0; n < SCRIPT_ROWS; n++) begin
         if (script[n].set_cfg) begin
            wait_idle();
            program_timing(script[n].dly, script[n].per);
         end
         send_poll(script[n].buttons, script[n].stamp, script[n].rearm,
                   script[n].typed, script[n].act);
      end

      btn = '0;
      tcur = 48'd1000;
      for (int p = 0; p < 6; p++) begin
         wait_idle();
         program_timing(phase_dly[p], phase_per[p]);
         // Steps are sized so that holds cross the delay within a few polls.
         scale = ((phase_dly[p] > phase_per[p]) ? phase_dly[p] : phase_per[p]) / 3 + 8;
         for (int k = 0; k < PHASE_POLLS; k++) begin
            r = $urandom_range(0, 99);
            if (r < 55) btn = btn;
            else if (r < 85) btn[$urandom_range(bea_pkg::BTN_DOWN, bea_pkg::BTN_BACK)] ^= 1'b1;
            else if (r < 95) btn[$urandom_range(0, bea_pkg::BTN_WIDTH - 1)] ^= 1'b1;
            else btn = 10'($urandom());
            r = $urandom_range(0, 99);
            if (r < 75) tcur = tcur + $urandom_range(0, scale);
            else if (r < 85) tcur = tcur;
            else if (r < 90) tcur = tcur + $urandom_range(1, 3);
            else if (r < 95) tcur = 48'({$urandom(), $urandom()});
            else tcur = tcur - $urandom_range(1, scale);
            rearm = ($urandom_range(0, 39) == 0);
            send_poll(btn, tcur, rearm, 1'b0, bea_pkg::CMD_NONE);
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && expected_actions.size() == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+src
src/bea_pkg.sv
src/bea_press_detect.sv
src/bea_dir_timer.sv
src/button_edge_autorepeat_top.sv
bench/tb_top.sv
